// ----- design/mhc_pkg.sv -----
// Shared constants, codes and types for the mirrored hit-count histogram.
// No dependencies; every other design file imports this package.
`timescale 1ns / 1ps

package mhc_pkg;

    // Image geometry: only rows 0..HALF_SIDE are stored.
    localparam int HALF_SIDE   = 256;
    localparam int SIDE        = 2 * HALF_SIDE + 1;
    localparam int ROWS        = HALF_SIDE + 1;
    localparam int STORE_WORDS = SIDE * ROWS;
    localparam int IDX_W       = $clog2(STORE_WORDS);
    localparam int COL_W       = $clog2(SIDE);
    localparam int ROW_W       = $clog2(ROWS);

    // Integer part of (Q8.24 magnitude * Q16.16 scale) is product[63:40].
    localparam int WHOLE_W     = 24;

    // Item kinds.
    localparam logic [1:0] KIND_PLANE = 2'd0;
    localparam logic [1:0] KIND_PIXEL = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;
    localparam logic [1:0] KIND_CLEAR = 2'd3;

    // Configuration register indexes.
    localparam int         CFG_IDX_W        = 1;
    localparam logic [0:0] CFG_SCALE_BACK   = 1'b0;
    localparam logic [0:0] CFG_PLANE_OFFSET = 1'b1;

    localparam logic [31:0] SCALE_RESET  = 32'd336199;
    localparam logic [31:0] OFFSET_RESET = 32'd0;
    localparam logic [31:0] COUNT_MAX    = 32'hFFFF_FFFF;

    // Queue between front and back.
    localparam int QDEPTH = 8;
    localparam int Q_AW   = $clog2(QDEPTH);
    localparam int Q_CW   = $clog2(QDEPTH + 1);

    // Classified item handed from front to back.
    typedef struct packed {
        logic [1:0]       kind;
        logic             ok;
        logic [IDX_W-1:0] idx;
    } op_t;

    // One result item.
    typedef struct packed {
        logic [31:0] count;
        logic [31:0] peak;
        logic        in_range;
    } res_t;

endpackage

// ----- design/mirrored_hit_count_histogram_unit.sv -----
// Top level of the mirrored hit-count histogram: front end, queue, back end.
// Depends on mhc_pkg, mhc_front, mhc_queue and mhc_back.
//
// Usage:
//   An item is taken on a rising edge with start high and busy low. kind
//   selects a hit at plane coordinates (plane_x/plane_y, Q8.24), a hit at
//   pixel_col/pixel_row, a read of one pixel, or a clear of the image.
//   Every item gives one result on pixel_count, max_count and in_range,
//   shown for exactly one cycle with done high; it must be taken then.
//   The user writes scale_back and plane_offset via cfg_write, cfg_index and
//   cfg_data only while the block is idle (unchecked). No read-back.
// Timing:
//   The front end is a 5-stage pipeline (subtract, magnitude, 32x32
//   multiply, range/fold, index). Out-of-range items report from the idle
//   state; in-range hits and reads pass the update state too. The back end
//   does a registered read then a write on the count store, so it takes a
//   new hit or read only after the update; up to 8 items may be in flight
//   before busy. A clear sweeps all 131841 store words, one per cycle, and
//   reports when done; busy stays high during the sweep.
// Reset:
//   Reset loads the register defaults and runs the same clearing sweep with
//   busy high and no result.
`timescale 1ns / 1ps

module mirrored_hit_count_histogram_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    kind,
    input  logic [11:0]                   pixel_col,
    input  logic [11:0]                   pixel_row,
    input  logic signed [31:0]            plane_x,
    input  logic signed [31:0]            plane_y,
    input  logic                          cfg_write,
    input  logic [mhc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                   cfg_data,
    output logic                          done,
    output logic [31:0]                   pixel_count,
    output logic [31:0]                   max_count,
    output logic                          in_range
);
    import mhc_pkg::*;

    logic            take;
    logic            push, pop, q_empty, sweeping;
    op_t             push_op, q_head;
    res_t            res;
    logic [Q_CW-1:0] inflight_reg;

    // Items between acceptance and the back end popping them
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            inflight_reg <= '0;
        else if (take && !pop)
            inflight_reg <= inflight_reg + 1'b1;
        else if (pop && !take)
            inflight_reg <= inflight_reg - 1'b1;
    end

    assign busy = sweeping || (inflight_reg >= Q_CW'(QDEPTH));
    assign take = start && !busy;

    mhc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .kind      (kind),
        .pixel_col (pixel_col),
        .pixel_row (pixel_row),
        .plane_x   (plane_x),
        .plane_y   (plane_y),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push),
        .push_op   (push_op)
    );

    mhc_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_op (push_op),
        .pop     (pop),
        .empty   (q_empty),
        .head    (q_head)
    );

    mhc_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_head   (q_head),
        .q_pop    (pop),
        .sweeping (sweeping),
        .done     (done),
        .res      (res)
    );

    assign pixel_count = res.count;
    assign max_count   = res.peak;
    assign in_range    = res.in_range;

endmodule

// ----- design/mhc_front.sv -----
// Front end: configuration registers, plane-to-pixel conversion, range
// check, row folding and store index. Depends on mhc_pkg.
`timescale 1ns / 1ps

module mhc_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          take,
    input  logic [1:0]                    kind,
    input  logic [11:0]                   pixel_col,
    input  logic [11:0]                   pixel_row,
    input  logic signed [31:0]            plane_x,
    input  logic signed [31:0]            plane_y,
    input  logic                          cfg_write,
    input  logic [mhc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                   cfg_data,
    output logic                          push,
    output mhc_pkg::op_t                  push_op
);
    import mhc_pkg::*;

    logic [31:0] scale_reg;
    logic [31:0] offset_reg;

    // stage valids
    logic s1_vld_reg, s2_vld_reg, s3_vld_reg, s4_vld_reg, s5_vld_reg;

    // stage 1: differences
    logic [1:0]         s1_kind_reg;
    logic [11:0]        s1_col_reg, s1_row_reg;
    logic signed [32:0] s1_dx_reg, s1_dy_reg;
    logic signed [32:0] s1_dx_next, s1_dy_next;

    // stage 2: sign and magnitude
    logic [1:0]  s2_kind_reg;
    logic [11:0] s2_col_reg, s2_row_reg;
    logic        s2_nx_reg, s2_ny_reg;
    logic [31:0] s2_mx_reg, s2_my_reg;
    logic [31:0] s2_mx_next, s2_my_next;

    // stage 3: scaled integer part
    logic [1:0]         s3_kind_reg;
    logic [11:0]        s3_col_reg, s3_row_reg;
    logic               s3_nx_reg, s3_ny_reg;
    logic [WHOLE_W-1:0] s3_wx_reg, s3_wy_reg;
    logic [63:0]        prod_x, prod_y;

    // stage 4: range check and fold
    logic [1:0]         s4_kind_reg;
    logic               s4_ok_reg;
    logic [COL_W-1:0]   s4_col_reg;
    logic [ROW_W-1:0]   s4_row_reg;
    logic [WHOLE_W-1:0] px, py, row_f;
    logic               conv_ok, s4_ok_next;

    // stage 5: store index
    op_t s5_op_reg;
    op_t s5_op_next;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg  <= SCALE_RESET;
            offset_reg <= OFFSET_RESET;
        end
        else if (cfg_write)
        begin
            if (cfg_index == CFG_SCALE_BACK)
                scale_reg <= cfg_data;
            else if (cfg_index == CFG_PLANE_OFFSET)
                offset_reg <= cfg_data;
        end
    end

    // Valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            s4_vld_reg <= 1'b0;
            s5_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= take;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
            s4_vld_reg <= s3_vld_reg;
            s5_vld_reg <= s4_vld_reg;
        end
    end

    // Stage 1: subtract the offset, sign-extended to 33 bits
    always_comb
    begin
        s1_dx_next = {plane_x[31], plane_x} - {offset_reg[31], offset_reg};
        s1_dy_next = {plane_y[31], plane_y} - {offset_reg[31], offset_reg};
    end

    // Stage 2: magnitude fits 32 bits since |diff| < 2^32
    always_comb
    begin
        s2_mx_next = s1_dx_reg[32] ? (~s1_dx_reg[31:0] + 32'd1) : s1_dx_reg[31:0];
        s2_my_next = s1_dy_reg[32] ? (~s1_dy_reg[31:0] + 32'd1) : s1_dy_reg[31:0];
    end

    // Stage 3: one 32x32 multiply per axis
    always_comb
    begin
        prod_x = {32'd0, s2_mx_reg} * {32'd0, scale_reg};
        prod_y = {32'd0, s2_my_reg} * {32'd0, scale_reg};
    end

    // Stage 4: pick coordinates, check range, fold rows past the middle
    always_comb
    begin
        if (s3_kind_reg == KIND_PLANE)
        begin
            px      = s3_wx_reg;
            py      = s3_wy_reg;
            // negative values in (-1,0) truncate to zero and stay valid
            conv_ok = !(s3_nx_reg && (s3_wx_reg != '0))
                   && !(s3_ny_reg && (s3_wy_reg != '0));
        end
        else
        begin
            px      = WHOLE_W'(s3_col_reg);
            py      = WHOLE_W'(s3_row_reg);
            conv_ok = 1'b1;
        end
        s4_ok_next = conv_ok && (s3_kind_reg != KIND_CLEAR)
                  && (px < WHOLE_W'(SIDE)) && (py < WHOLE_W'(SIDE));
        row_f = (py >= WHOLE_W'(ROWS)) ? (WHOLE_W'(SIDE) - py) : py;
    end

    // Stage 5: row * SIDE + col
    always_comb
    begin
        s5_op_next.kind = s4_kind_reg;
        s5_op_next.ok   = s4_ok_reg;
        s5_op_next.idx  = IDX_W'(int'(s4_row_reg) * SIDE + int'(s4_col_reg));
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        s1_kind_reg <= kind;
        s1_col_reg  <= pixel_col;
        s1_row_reg  <= pixel_row;
        s1_dx_reg   <= s1_dx_next;
        s1_dy_reg   <= s1_dy_next;

        s2_kind_reg <= s1_kind_reg;
        s2_col_reg  <= s1_col_reg;
        s2_row_reg  <= s1_row_reg;
        s2_nx_reg   <= s1_dx_reg[32];
        s2_ny_reg   <= s1_dy_reg[32];
        s2_mx_reg   <= s2_mx_next;
        s2_my_reg   <= s2_my_next;

        s3_kind_reg <= s2_kind_reg;
        s3_col_reg  <= s2_col_reg;
        s3_row_reg  <= s2_row_reg;
        s3_nx_reg   <= s2_nx_reg;
        s3_ny_reg   <= s2_ny_reg;
        s3_wx_reg   <= prod_x[63:40];
        s3_wy_reg   <= prod_y[63:40];

        s4_kind_reg <= s3_kind_reg;
        s4_ok_reg   <= s4_ok_next;
        s4_col_reg  <= COL_W'(px);
        s4_row_reg  <= ROW_W'(row_f);

        s5_op_reg   <= s5_op_next;
    end

    assign push    = s5_vld_reg;
    assign push_op = s5_op_reg;

endmodule

// ----- design/mhc_queue.sv -----
// Small FIFO of classified items between front and back ends.
// Depends on mhc_pkg; the producer never pushes when full.
`timescale 1ns / 1ps

module mhc_queue (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  mhc_pkg::op_t push_op,
    input  logic         pop,
    output logic         empty,
    output mhc_pkg::op_t head
);
    import mhc_pkg::*;

    op_t            slot_reg [QDEPTH];
    logic [Q_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [Q_CW-1:0] cnt_reg;

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_op;
    end

    assign empty = (cnt_reg == '0);
    assign head  = slot_reg[rd_ptr_reg];

endmodule

// ----- design/mhc_back.sv -----
// Back end: count store with read-modify-write, running peak, clearing
// sweep and result registers. Depends on mhc_pkg.
`timescale 1ns / 1ps

module mhc_back (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         q_empty,
    input  mhc_pkg::op_t q_head,
    output logic         q_pop,
    output logic         sweeping,
    output logic         done,
    output mhc_pkg::res_t res
);
    import mhc_pkg::*;

    localparam logic [1:0] ST_SWEEP = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_UPD   = 2'd2;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(STORE_WORDS - 1);

    logic [31:0] store [STORE_WORDS];

    logic [1:0]       state_reg, state_next;
    logic [IDX_W-1:0] ptr_reg, ptr_next;
    logic             clr_reg, clr_next;
    logic [31:0]      peak_reg, peak_next;
    logic             done_reg, done_next;
    res_t             res_reg, res_next;

    logic [31:0]      rd_data_reg;
    logic [1:0]       upd_kind_reg;
    logic [IDX_W-1:0] upd_idx_reg;

    logic             mem_we;
    logic [IDX_W-1:0] mem_wa;
    logic [31:0]      mem_wd;
    logic [31:0]      new_count;

    // Saturating increment of the fetched count
    assign new_count = (rd_data_reg == COUNT_MAX) ? rd_data_reg : rd_data_reg + 32'd1;

    // Store write port: zero during a sweep, new count after a hit
    always_comb
    begin
        mem_we = (state_reg == ST_SWEEP)
              || ((state_reg == ST_UPD) && (upd_kind_reg != KIND_READ));
        mem_wa = (state_reg == ST_SWEEP) ? ptr_reg : upd_idx_reg;
        mem_wd = (state_reg == ST_SWEEP) ? 32'd0 : new_count;
    end

    // Count store, registered read at the head item's index
    always_ff @(posedge clk)
    begin
        if (mem_we)
            store[mem_wa] <= mem_wd;
        rd_data_reg <= store[q_head.idx];
    end

    assign q_pop = (state_reg == ST_IDLE) && !q_empty;

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        ptr_next   = ptr_reg;
        clr_next   = clr_reg;
        peak_next  = peak_reg;
        done_next  = 1'b0;
        res_next   = res_reg;
        case (state_reg)
            ST_SWEEP:
            begin
                ptr_next = ptr_reg + 1'b1;
                if (ptr_reg == LAST_IDX)
                begin
                    ptr_next   = '0;
                    state_next = ST_IDLE;
                    // a clear item reports once the sweep ends
                    if (clr_reg)
                    begin
                        clr_next          = 1'b0;
                        done_next         = 1'b1;
                        res_next.count    = 32'd0;
                        res_next.peak     = 32'd0;
                        res_next.in_range = 1'b0;
                    end
                end
            end
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    if (q_head.kind == KIND_CLEAR)
                    begin
                        state_next = ST_SWEEP;
                        clr_next   = 1'b1;
                        peak_next  = 32'd0;
                    end
                    else if (!q_head.ok)
                    begin
                        done_next         = 1'b1;
                        res_next.count    = 32'd0;
                        res_next.peak     = peak_reg;
                        res_next.in_range = 1'b0;
                    end
                    else
                    begin
                        state_next = ST_UPD;
                    end
                end
            end
            ST_UPD:
            begin
                state_next = ST_IDLE;
                done_next  = 1'b1;
                if (upd_kind_reg == KIND_READ)
                begin
                    res_next.count = rd_data_reg;
                end
                else
                begin
                    res_next.count = new_count;
                    if (new_count > peak_reg)
                        peak_next = new_count;
                end
                res_next.peak     = peak_next;
                res_next.in_range = 1'b1;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state; reset starts the clearing sweep
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_SWEEP;
            ptr_reg   <= '0;
            clr_reg   <= 1'b0;
            peak_reg  <= 32'd0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ptr_reg   <= ptr_next;
            clr_reg   <= clr_next;
            peak_reg  <= peak_next;
            done_reg  <= done_next;
        end
    end

    // Payload: item under update and result
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            upd_kind_reg <= q_head.kind;
            upd_idx_reg  <= q_head.idx;
        end
        res_reg <= res_next;
    end

    assign sweeping = (state_reg == ST_SWEEP);
    assign done     = done_reg;
    assign res      = res_reg;

endmodule

// ----- verif/mhc_result_checker.sv -----
// Result checker for the mirrored hit-count histogram: watches the item, config and result ports.
// Keeps its own copy of the image, peak and registers, and compares each result in order.
// Depends on mhc_pkg.
`timescale 1ns / 1ps

module mhc_result_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic                          busy,
    input  logic [1:0]                    kind,
    input  logic [11:0]                   pixel_col,
    input  logic [11:0]                   pixel_row,
    input  logic signed [31:0]            plane_x,
    input  logic signed [31:0]            plane_y,
    input  logic                          cfg_write,
    input  logic [mhc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                   cfg_data,
    input  logic                          done,
    input  logic [31:0]                   pixel_count,
    input  logic [31:0]                   max_count,
    input  logic                          in_range,
    output int                            mismatches,
    output int                            pending
);

    import mhc_pkg::*;

    // Shadow image (lower half only), peak and registers
    logic [31:0] image_counts [0:STORE_WORDS-1];
    logic [31:0] peak_seen;
    logic [31:0] scale_q16;
    logic [31:0] offset_q24;

    // Results predicted but not yet seen, oldest first
    res_t expected_results [$];
    int   error_total;

    task automatic clear_image();
        for (int i = 0; i < STORE_WORDS; i++)
        begin
            image_counts[i] = '0;
        end
        peak_seen = '0;
    endtask

    // trunc((coord - offset) * scale); false when the result is -1 or below
    function automatic bit plane_to_pixel(input logic [31:0] coord, output logic [31:0] pix);
        logic signed [63:0] diff;
        logic [63:0]        mag;
        logic [63:0]        prod;
        logic [63:0]        whole;
        bit                 neg;
        diff  = $signed({{32{coord[31]}}, coord}) - $signed({{32{offset_q24[31]}}, offset_q24});
        neg   = diff[63];
        mag   = neg ? 64'(-diff) : 64'(diff);
        prod  = mag * {32'd0, scale_q16};
        whole = prod >> 40;
        pix   = whole[31:0];
        return !(neg && whole != 0);
    endfunction

    // Range check, fold of the upper half onto the lower, and word address
    function automatic bit fold_index(input logic [31:0] col, input logic [31:0] row,
                                      output logic [IDX_W-1:0] idx);
        logic [31:0] r;
        r   = row;
        idx = '0;
        if (col >= SIDE || row >= SIDE)
            return 0;
        if (r >= ROWS)
            r = SIDE - r;
        idx = IDX_W'(r * SIDE + col);
        return 1;
    endfunction

    // Apply one item to the shadow image and queue the result it should give
    task automatic update_histogram();
        res_t             res;
        logic [31:0]      px;
        logic [31:0]      py;
        logic [31:0]      cnt;
        logic [IDX_W-1:0] idx;
        bit               ok_x;
        bit               ok_y;
        bit               hit;
        cnt = '0;
        hit = 0;
        idx = '0;
        if (kind == KIND_CLEAR)
        begin
            clear_image();
        end
        else
        begin
            if (kind == KIND_PLANE)
            begin
                ok_x = plane_to_pixel(plane_x, px);
                ok_y = plane_to_pixel(plane_y, py);
                hit  = ok_x && ok_y && fold_index(px, py, idx);
            end
            else
            begin
                hit = fold_index({20'd0, pixel_col}, {20'd0, pixel_row}, idx);
            end
            if (hit)
            begin
                cnt = image_counts[idx];
                if (kind != KIND_READ)
                begin
                    // saturating increment
                    if (cnt != COUNT_MAX)
                        cnt = cnt + 1;
                    image_counts[idx] = cnt;
                    if (cnt > peak_seen)
                        peak_seen = cnt;
                end
            end
        end
        res.count    = cnt;
        res.peak     = peak_seen;
        res.in_range = hit;
        expected_results.push_back(res);
    endtask

    task automatic compare_result();
        res_t want;
        if (expected_results.size() == 0)
        begin
            error_total++;
            if (error_total <= 10)
                $display("%0t: result with no item outstanding: count=%h max=%h in_range=%b",
                         $realtime, pixel_count, max_count, in_range);
        end
        else
        begin
            want = expected_results.pop_front();
            if (want.count !== pixel_count || want.peak !== max_count
                || want.in_range !== in_range)
            begin
                error_total++;
                if (error_total <= 10)
                    $display("%0t: mismatch: count exp=%h got=%h, max exp=%h got=%h, in_range exp=%b got=%b",
                             $realtime, want.count, pixel_count, want.peak, max_count,
                             want.in_range, in_range);
            end
        end
    endtask

    // Results retire before the item of the same edge is queued
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_image();
            scale_q16   = SCALE_RESET;
            offset_q24  = OFFSET_RESET;
            expected_results.delete();
            error_total = 0;
            mismatches <= 0;
            pending    <= 0;
        end
        else
        begin
            if (done)
                compare_result();
            if (cfg_write)
            begin
                if (cfg_index == CFG_SCALE_BACK)
                    scale_q16 = cfg_data;
                else if (cfg_index == CFG_PLANE_OFFSET)
                    offset_q24 = cfg_data;
            end
            if (start && !busy)
                update_histogram();
            mismatches <= error_total;
            pending    <= expected_results.size();
        end
    end

endmodule

// ----- verif/mirrored_hit_count_histogram_unit_test.sv -----
// Top of the mirrored hit-count histogram testbench: clock, reset, stimulus and verdict.
// Depends on mhc_pkg, mirrored_hit_count_histogram_unit and mhc_result_checker.
`timescale 1ns / 1ps

module mirrored_hit_count_histogram_unit_test;

    import mhc_pkg::*;

    // Reset sweep plus three clear sweeps dominate the run; allow several times that
    localparam int CYCLE_LIMIT = 3_000_000;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic [1:0]           kind;
    logic [11:0]          pixel_col;
    logic [11:0]          pixel_row;
    logic signed [31:0]   plane_x;
    logic signed [31:0]   plane_y;
    logic                 cfg_write;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [31:0]          cfg_data;
    logic                 done;
    logic [31:0]          pixel_count;
    logic [31:0]          max_count;
    logic                 in_range;

    int          mismatches;
    int          pending;
    int          cycle_count;
    logic [31:0] cur_scale;
    logic [31:0] cur_offset;
    int          hot_col;
    int          hot_row;
    bit          idle_on;

    mirrored_hit_count_histogram_unit i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .kind        (kind),
        .pixel_col   (pixel_col),
        .pixel_row   (pixel_row),
        .plane_x     (plane_x),
        .plane_y     (plane_y),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .done        (done),
        .pixel_count (pixel_count),
        .max_count   (max_count),
        .in_range    (in_range)
    );

    mhc_result_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .kind        (kind),
        .pixel_col   (pixel_col),
        .pixel_row   (pixel_row),
        .plane_x     (plane_x),
        .plane_y     (plane_y),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .done        (done),
        .pixel_count (pixel_count),
        .max_count   (max_count),
        .in_range    (in_range),
        .mismatches  (mismatches),
        .pending     (pending)
    );

    // 10 ns clock
    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // Present one item and hold it until the block takes it
    task automatic send_item(input logic [1:0] k, input logic [11:0] col, input logic [11:0] row,
                             input logic [31:0] px, input logic [31:0] py);
        @(negedge clk);
        start     = 1'b1;
        kind      = k;
        pixel_col = col;
        pixel_row = row;
        plane_x   = px;
        plane_y   = py;
        do
            @(posedge clk);
        while (busy);
    endtask

    task automatic idle_gap(input int n);
        @(negedge clk);
        start = 1'b0;
        repeat (n - 1) @(negedge clk);
    endtask

    // Hold off until every queued result is back and the block is quiet
    task automatic wait_drained();
        @(negedge clk);
        start = 1'b0;
        do
            @(posedge clk);
        while (pending != 0 || busy);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        @(negedge clk);
        cfg_write = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(negedge clk);
        cfg_write = 1'b0;
    endtask

    task automatic set_config(input logic [31:0] scale, input logic [31:0] offset);
        wait_drained();
        write_reg(CFG_SCALE_BACK, scale);
        write_reg(CFG_PLANE_OFFSET, offset);
        cur_scale  = scale;
        cur_offset = offset;
        hot_col    = $urandom_range(0, SIDE - 3);
        hot_row    = $urandom_range(0, ROWS - 3);
    endtask

    // Plane coordinate that mostly lands near the image for the current scale
    function automatic logic [31:0] plane_coord();
        logic [63:0] span;
        logic [31:0] d;
        if ($urandom_range(0, 4) == 0)
            return $urandom();
        if (cur_scale == 0)
            span = 64'h7FFF_FFFF;
        else
            span = (64'd600 << 40) / {32'd0, cur_scale};
        if (span > 64'h7FFF_FFFF)
            span = 64'h7FFF_FFFF;
        d = $urandom_range(0, span[31:0]);
        // slightly below the offset: tiny values still truncate to pixel 0
        if ($urandom_range(0, 9) == 0)
            return cur_offset - (d >> $urandom_range(6, 12));
        return cur_offset + d;
    endfunction

    // Pixel address: full field range, a hot spot (often mirrored), or near the image
    task automatic pick_pixel(output logic [11:0] col, output logic [11:0] row);
        int r;
        r = $urandom_range(0, 99);
        if (r < 15)
        begin
            col = 12'($urandom());
            row = 12'($urandom());
        end
        else if (r < 45)
        begin
            col = 12'(hot_col + $urandom_range(0, 2));
            row = 12'(hot_row + $urandom_range(0, 2));
            if ($urandom_range(0, 1) == 1)
                row = 12'(SIDE) - row;
        end
        else
        begin
            col = 12'($urandom_range(0, SIDE));
            row = 12'($urandom_range(0, SIDE));
        end
    endtask

    task automatic random_items(input int n, input bit idle_allowed);
        int          r;
        logic [11:0] col;
        logic [11:0] row;
        for (int i = 0; i < n; i++)
        begin
            // idle in some stretches, none in others
            if (i % 50 == 0)
                idle_on = idle_allowed && ($urandom_range(0, 2) != 0);
            if (idle_on && $urandom_range(0, 3) == 0)
                idle_gap($urandom_range(1, 16));
            r = $urandom_range(0, 99);
            if (r < 35)
            begin
                send_item(KIND_PLANE, 12'($urandom()), 12'($urandom()),
                          plane_coord(), plane_coord());
            end
            else
            begin
                pick_pixel(col, row);
                send_item((r < 75) ? KIND_PIXEL : KIND_READ, col, row, $urandom(), $urandom());
            end
        end
    endtask

    initial
    begin
        rst_n       = 1'b0;
        start       = 1'b0;
        kind        = KIND_READ;
        pixel_col   = '0;
        pixel_row   = '0;
        plane_x     = '0;
        plane_y     = '0;
        cfg_write   = 1'b0;
        cfg_index   = CFG_SCALE_BACK;
        cfg_data    = '0;
        cycle_count = 0;
        idle_on     = 1'b0;
        cur_scale   = SCALE_RESET;
        cur_offset  = OFFSET_RESET;
        hot_col     = 100;
        hot_row     = 20;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // clearing sweep after reset
        do
            @(posedge clk);
        while (busy);

        // Directed part, reset register values (about 5.13 pixels per unit)
        send_item(KIND_PIXEL, 12'd0, 12'd0, $urandom(), $urandom());
        send_item(KIND_PIXEL, 12'd512, 12'd0, $urandom(), $urandom());
        send_item(KIND_PIXEL, 12'd0, 12'd256, $urandom(), $urandom());
        // first folded row lands on the last stored one
        send_item(KIND_PIXEL, 12'd0, 12'd257, $urandom(), $urandom());
        send_item(KIND_PIXEL, 12'd512, 12'd512, $urandom(), $urandom());
        // out of range: column, row, field maximum
        send_item(KIND_PIXEL, 12'd513, 12'd0, $urandom(), $urandom());
        send_item(KIND_PIXEL, 12'd0, 12'd513, $urandom(), $urandom());
        send_item(KIND_PIXEL, 12'hFFF, 12'hFFF, $urandom(), $urandom());
        send_item(KIND_READ, 12'd0, 12'd256, $urandom(), $urandom());
        send_item(KIND_READ, 12'hFFF, 12'd0, $urandom(), $urandom());
        // plane hits: 50.0 -> col 256, 60.0 -> row 307, folded to 206
        send_item(KIND_PLANE, 12'($urandom()), 12'($urandom()), 32'h3200_0000, 32'h3C00_0000);
        send_item(KIND_PLANE, 12'($urandom()), 12'($urandom()), 32'h0000_0000, 32'h0000_0000);
        // just below zero truncates to pixel 0
        send_item(KIND_PLANE, 12'($urandom()), 12'($urandom()), 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        // -0.25 maps below -1 pixel: out
        send_item(KIND_PLANE, 12'($urandom()), 12'($urandom()), 32'hFFC0_0000, 32'h0000_0000);
        send_item(KIND_PLANE, 12'($urandom()), 12'($urandom()), 32'h8000_0000, 32'h0100_0000);
        send_item(KIND_PLANE, 12'($urandom()), 12'($urandom()), 32'h7FFF_FFFF, 32'h0100_0000);
        // 100.0 maps to 512.99, just inside on the last column or row
        send_item(KIND_PLANE, 12'($urandom()), 12'($urandom()), 32'h6400_0000, 32'h0100_0000);
        send_item(KIND_PLANE, 12'($urandom()), 12'($urandom()), 32'h0100_0000, 32'h6400_0000);
        send_item(KIND_READ, 12'd0, 12'd0, $urandom(), $urandom());
        send_item(KIND_CLEAR, 12'($urandom()), 12'($urandom()), $urandom(), $urandom());
        send_item(KIND_READ, 12'd0, 12'd0, $urandom(), $urandom());
        send_item(KIND_PIXEL, 12'd256, 12'd256, $urandom(), $urandom());
        random_items(200, 1'b1);

        // Extreme settings: finest scale, most negative offset
        set_config(32'hFFFF_FFFF, 32'h8000_0000);
        random_items(180, 1'b1);

        // Zero scale maps every plane point to pixel 0; largest offset
        set_config(32'h0000_0000, 32'h7FFF_FFFF);
        send_item(KIND_CLEAR, 12'($urandom()), 12'($urandom()), $urandom(), $urandom());
        random_items(180, 1'b1);

        // Unit scale, random offset
        set_config(32'h0001_0000, $urandom());
        random_items(180, 1'b1);

        set_config($urandom(), $urandom());
        send_item(KIND_CLEAR, 12'($urandom()), 12'($urandom()), $urandom(), $urandom());
        random_items(180, 1'b1);

        // Back to defaults, no idling to the end
        set_config(SCALE_RESET, OFFSET_RESET);
        random_items(160, 1'b0);

        wait_drained();
        if (mismatches == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ----- files.f -----
design/mhc_pkg.sv
design/mhc_front.sv
design/mhc_queue.sv
design/mhc_back.sv
design/mirrored_hit_count_histogram_unit.sv
verif/mhc_result_checker.sv
verif/mirrored_hit_count_histogram_unit_test.sv
